### hdl/mdfs_pkg.sv
// ----------------------------------------------------------------------------
// mdfs_pkg
// Shared types, constants and helper functions for the maze carving core.
// ----------------------------------------------------------------------------
package mdfs_pkg;

  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 32;

  localparam int COORD_W = 5;
  localparam int RAND_W  = 16;
  localparam int CFG_W   = 6;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int EPOCH_W = 4;

  localparam logic [CFG_W-1:0] ROWS_RESET = 6'd32;
  localparam logic [CFG_W-1:0] COLS_RESET = 6'd32;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam int MOD3_SHIFT = 17;
  localparam int PROD_W     = RAND_W + MOD3_SHIFT;
  localparam logic [MOD3_SHIFT-1:0] MOD3_RECIP = 17'd43691;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] start_row;
    logic [RAND_W-1:0]  rand_value;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic               advanced;
    logic [1:0]         direction;
    logic               done_res;
  } result_t;

  typedef struct packed {
    logic       load;
    logic [1:0] rd_dir;
    logic       cap;
    logic       sweep;
    logic       init;
    logic       step;
  } ctrl_t;

  typedef struct packed {
    logic epoch_full;
    logic sweep_last;
  } stat_t;

  function automatic logic [1:0] mod3(input logic [RAND_W-1:0] x);
    logic [PROD_W-1:0] prod;
    logic [RAND_W-1:0] q;
    logic [RAND_W-1:0] r;
    prod = PROD_W'(x) * PROD_W'(MOD3_RECIP);
    q = prod[MOD3_SHIFT +: RAND_W];
    r = x - q - RAND_W'({q, 1'b0});
    return r[1:0];
  endfunction

  function automatic logic [1:0] pick_dir(input logic [3:0] cand, input logic [1:0] idx);
    logic [1:0] seen;
    logic [1:0] dir;
    seen = '0;
    dir  = DIR_UP;
    for (int d = 0; d < 4; d++) begin
      if (cand[d]) begin
        if (seen == idx) dir = 2'(d);
        seen = seen + 2'd1;
      end
    end
    return dir;
  endfunction

endpackage

### hdl/mdfs_ram.sv
// ----------------------------------------------------------------------------
// mdfs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### hdl/mdfs_ctrl.sv
// ----------------------------------------------------------------------------
// mdfs_ctrl
// Sequencer: neighbor reads, evaluate, visited-store sweep and start setup.
// ----------------------------------------------------------------------------
module mdfs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            start_cmd,
  input  mdfs_pkg::stat_t stat,
  output logic            busy,
  output mdfs_pkg::ctrl_t ctrl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD1   = 3'd1;
  localparam logic [2:0] S_RD2   = 3'd2;
  localparam logic [2:0] S_RD3   = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_SWEEP = 3'd5;
  localparam logic [2:0] S_INIT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctrl        = '0;
    ctrl.rd_dir = mdfs_pkg::DIR_UP;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          if (start_cmd == mdfs_pkg::CMD_STEP) state_next = S_RD1;
          else if (stat.epoch_full) state_next = S_SWEEP;
          else state_next = S_INIT;
        end
      end
      S_RD1: begin
        ctrl.rd_dir = mdfs_pkg::DIR_LEFT;
        ctrl.cap    = 1'b1;
        state_next  = S_RD2;
      end
      S_RD2: begin
        ctrl.rd_dir = mdfs_pkg::DIR_RIGHT;
        ctrl.cap    = 1'b1;
        state_next  = S_RD3;
      end
      S_RD3: begin
        ctrl.rd_dir = mdfs_pkg::DIR_DOWN;
        ctrl.cap    = 1'b1;
        state_next  = S_EVAL;
      end
      S_EVAL: begin
        ctrl.step  = 1'b1;
        state_next = S_IDLE;
      end
      S_SWEEP: begin
        ctrl.sweep = 1'b1;
        if (stat.sweep_last) state_next = S_INIT;
      end
      S_INIT: begin
        ctrl.init  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

### hdl/mdfs_dpath.sv
// ----------------------------------------------------------------------------
// mdfs_dpath
// Datapath: current cell, epoch-tagged visited store, path stack, result word.
// ----------------------------------------------------------------------------
module mdfs_dpath #(
  parameter int MAX_ROWS = mdfs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mdfs_pkg::MAX_COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mdfs_pkg::ctrl_t              ctrl,
  output mdfs_pkg::stat_t              stat,
  input  mdfs_pkg::item_t              item,
  input  logic [mdfs_pkg::CFG_W-1:0]   cell_rows,
  input  logic [mdfs_pkg::CFG_W-1:0]   cell_cols,
  output mdfs_pkg::result_t            res,
  output logic                         res_strobe
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int XW    = ((RW > CW) ? RW : CW) + 7;
  localparam int EW    = mdfs_pkg::EPOCH_W;

  mdfs_pkg::item_t   item_q;
  mdfs_pkg::result_t res_q;
  mdfs_pkg::result_t res_next;
  logic [1:0]        r3_q;
  logic [2:0]        vis_q;
  logic [RW-1:0]     cur_row;
  logic [CW-1:0]     cur_col;
  logic [AW:0]       top;
  logic [AW:0]       top_m1;
  logic              finished;
  logic [EW-1:0]     epoch;
  logic [EW-1:0]     epoch_inc;
  logic [AW-1:0]     sweep_cnt;
  logic              strobe;

  logic [XW-1:0]     rows_x;
  logic [XW-1:0]     cols_x;
  logic [XW-1:0]     srow_x;
  logic [XW-1:0]     lim_x;
  logic [RW-1:0]     srow;
  logic [RW-1:0]     nb_row [4];
  logic [CW-1:0]     nb_col [4];
  logic [3:0]        inb;
  logic [3:0]        hits;
  logic [3:0]        cand;
  logic [2:0]        count;
  logic [1:0]        idx;
  logic [1:0]        dir_sel;
  logic              hit_now;
  logic              advance;

  logic              vis_we;
  logic [AW-1:0]     vis_waddr;
  logic [EW-1:0]     vis_wdata;
  logic [AW-1:0]     vis_raddr;
  logic [EW-1:0]     vis_rdata;
  logic              stk_we;
  logic [AW-1:0]     stk_rdata;
  logic [RW-1:0]     stk_row;
  logic [CW-1:0]     stk_col;

  always_comb begin
    if (cell_rows == '0) rows_x = XW'(1);
    else if (XW'(cell_rows) > XW'(MAX_ROWS)) rows_x = XW'(MAX_ROWS);
    else rows_x = XW'(cell_rows);
    if (cell_cols == '0) cols_x = XW'(1);
    else if (XW'(cell_cols) > XW'(MAX_COLS)) cols_x = XW'(MAX_COLS);
    else cols_x = XW'(cell_cols);
    srow_x = XW'(item_q.start_row);
    lim_x  = rows_x - XW'(1);
    srow   = (srow_x > lim_x) ? lim_x[RW-1:0] : srow_x[RW-1:0];
  end

  always_comb begin
    nb_row[mdfs_pkg::DIR_UP]    = cur_row - RW'(1);
    nb_col[mdfs_pkg::DIR_UP]    = cur_col;
    nb_row[mdfs_pkg::DIR_LEFT]  = cur_row;
    nb_col[mdfs_pkg::DIR_LEFT]  = cur_col - CW'(1);
    nb_row[mdfs_pkg::DIR_RIGHT] = cur_row;
    nb_col[mdfs_pkg::DIR_RIGHT] = cur_col + CW'(1);
    nb_row[mdfs_pkg::DIR_DOWN]  = cur_row + RW'(1);
    nb_col[mdfs_pkg::DIR_DOWN]  = cur_col;
    inb[mdfs_pkg::DIR_UP]    = (cur_row != '0) && (XW'(cur_row) <= rows_x) &&
                               (XW'(cur_col) < cols_x);
    inb[mdfs_pkg::DIR_LEFT]  = (cur_col != '0) && (XW'(cur_col) <= cols_x) &&
                               (XW'(cur_row) < rows_x);
    inb[mdfs_pkg::DIR_RIGHT] = ((XW'(cur_col) + XW'(1)) < cols_x) &&
                               (XW'(cur_row) < rows_x);
    inb[mdfs_pkg::DIR_DOWN]  = ((XW'(cur_row) + XW'(1)) < rows_x) &&
                               (XW'(cur_col) < cols_x);
  end

  assign vis_raddr = {nb_row[ctrl.rd_dir], nb_col[ctrl.rd_dir]};
  assign hit_now   = (vis_rdata == epoch);
  assign hits      = {hit_now, vis_q};
  assign cand      = inb & ~hits;
  assign count     = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);

  always_comb begin
    unique case (count)
      3'd2:    idx = {1'b0, item_q.rand_value[0]};
      3'd3:    idx = r3_q;
      3'd4:    idx = item_q.rand_value[1:0];
      default: idx = 2'd0;
    endcase
  end

  assign dir_sel   = mdfs_pkg::pick_dir(cand, idx);
  assign advance   = !finished && (count != 3'd0);
  assign top_m1    = top - (AW+1)'(1);
  assign epoch_inc = (&epoch) ? EW'(1) : epoch + EW'(1);
  assign stk_row   = stk_rdata[AW-1:CW];
  assign stk_col   = stk_rdata[CW-1:0];

  always_comb begin
    vis_we = ctrl.sweep | ctrl.init | (ctrl.step & advance);
    priority if (ctrl.sweep) begin
      vis_waddr = sweep_cnt;
      vis_wdata = '0;
    end else if (ctrl.init) begin
      vis_waddr = {srow, CW'(0)};
      vis_wdata = epoch_inc;
    end else begin
      vis_waddr = {nb_row[dir_sel], nb_col[dir_sel]};
      vis_wdata = epoch;
    end
  end

  assign stk_we = ctrl.step & advance;

  mdfs_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  mdfs_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (top[AW-1:0]),
    .wdata ({cur_row, cur_col}),
    .raddr (top_m1[AW-1:0]),
    .rdata (stk_rdata)
  );

  always_comb begin
    res_next           = '0;
    res_next.cell_row  = mdfs_pkg::COORD_W'(cur_row);
    res_next.cell_col  = mdfs_pkg::COORD_W'(cur_col);
    res_next.direction = mdfs_pkg::DIR_UP;
    priority if (ctrl.init) begin
      res_next.cell_row = mdfs_pkg::COORD_W'(srow);
      res_next.cell_col = '0;
    end else if (finished) begin
      res_next.done_res = 1'b1;
    end else if (count != 3'd0) begin
      res_next.cell_row  = mdfs_pkg::COORD_W'(nb_row[dir_sel]);
      res_next.cell_col  = mdfs_pkg::COORD_W'(nb_col[dir_sel]);
      res_next.advanced  = 1'b1;
      res_next.direction = dir_sel;
    end else if (top == '0) begin
      res_next.done_res = 1'b1;
    end else begin
      res_next.cell_row = mdfs_pkg::COORD_W'(stk_row);
      res_next.cell_col = mdfs_pkg::COORD_W'(stk_col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row   <= '0;
      cur_col   <= '0;
      top       <= '0;
      finished  <= 1'b1;
      epoch     <= '1;
      sweep_cnt <= '0;
      strobe    <= 1'b0;
    end else begin
      strobe <= ctrl.init | ctrl.step;
      if (ctrl.sweep) sweep_cnt <= sweep_cnt + AW'(1);
      if (ctrl.init) begin
        epoch    <= epoch_inc;
        cur_row  <= srow;
        cur_col  <= '0;
        top      <= '0;
        finished <= 1'b0;
      end else if (ctrl.step && !finished) begin
        if (count != 3'd0) begin
          cur_row <= nb_row[dir_sel];
          cur_col <= nb_col[dir_sel];
          top     <= top + (AW+1)'(1);
        end else if (top == '0) begin
          finished <= 1'b1;
        end else begin
          top     <= top_m1;
          cur_row <= stk_row;
          cur_col <= stk_col;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) item_q <= item;
    r3_q <= mdfs_pkg::mod3(item_q.rand_value);
    if (ctrl.cap) vis_q <= {hit_now, vis_q[2:1]};
    if (ctrl.init || ctrl.step) res_q <= res_next;
  end

  assign stat       = '{epoch_full: &epoch, sweep_last: &sweep_cnt};
  assign res        = res_q;
  assign res_strobe = strobe;

endmodule

### hdl/maze_dfs_carve_step_core.sv
// ----------------------------------------------------------------------------
// maze_dfs_carve_step_core
// Depth-first maze carving with backtracking, one search step per command.
//
//   channel  handshake                       word
//   item     start / busy                    item  (cmd, start_row, rand_value)
//   result   res_strobe, one cycle           res   (cell_row .. done_res)
//   config   psel penable pwrite pready      cell_rows @0x0, cell_cols @0x4
//
// A step reads the four neighbors in turn on the single read port of the
// visited store, then evaluates; the result strobe is registered from the evaluate state.
// A start sets up the start cell; the first start after reset, and every 15th
// after that, first clears all 2^(RW+CW) visited-store entries (1024 by default).
// A new item is taken in the cycle its predecessor's result is strobed.
// rst is synchronous and clears control state; results are never stalled.
// ----------------------------------------------------------------------------
module maze_dfs_carve_step_core #(
  parameter int MAX_ROWS = mdfs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mdfs_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  mdfs_pkg::item_t                item,
  output logic                           res_strobe,
  output mdfs_pkg::result_t              res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mdfs_pkg::PADDR_W-1:0]   paddr,
  input  logic [mdfs_pkg::PDATA_W-1:0]   pwdata,
  output logic [mdfs_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [mdfs_pkg::CFG_W-1:0] cell_rows;
  logic [mdfs_pkg::CFG_W-1:0] cell_cols;
  logic                       cfg_wr;
  mdfs_pkg::ctrl_t            ctrl;
  mdfs_pkg::stat_t            stat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_rows <= mdfs_pkg::ROWS_RESET;
      cell_cols <= mdfs_pkg::COLS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        mdfs_pkg::REG_ROWS: cell_rows <= pwdata[mdfs_pkg::CFG_W-1:0];
        mdfs_pkg::REG_COLS: cell_cols <= pwdata[mdfs_pkg::CFG_W-1:0];
        default:            cell_rows <= cell_rows;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mdfs_pkg::REG_ROWS: prdata = mdfs_pkg::PDATA_W'(cell_rows);
      mdfs_pkg::REG_COLS: prdata = mdfs_pkg::PDATA_W'(cell_cols);
      default:            prdata = '0;
    endcase
  end

  mdfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_cmd (item.cmd),
    .stat      (stat),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  mdfs_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .item       (item),
    .cell_rows  (cell_rows),
    .cell_cols  (cell_cols),
    .res        (res),
    .res_strobe (res_strobe)
  );

`ifndef SYNTHESIS
  a_step_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == mdfs_pkg::CMD_STEP) |-> ##5 res_strobe)
    else $error("step result not strobed five cycles after accept");

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    res_strobe |=> !res_strobe)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    res_strobe |-> !busy)
    else $error("result strobed while sequencer busy");

  a_done_no_move: assert property (@(posedge clk) disable iff (rst)
    res_strobe |-> !(res.done_res && res.advanced))
    else $error("completion reported together with a move");
`endif

endmodule

### verif/maze_carve_checker.sv
// ----------------------------------------------------------------------------
// maze_carve_checker
// Watches the item, result and register channels of the maze carving core,
// keeps its own copy of the visited grid, backtrack trail and bounds, works
// out the move each accepted item must produce and compares every result
// word, field by field, with the oldest move still due. Register reads are
// checked against the last value written.
// ----------------------------------------------------------------------------
module maze_carve_checker
  import mdfs_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  item_t              item,
  input  logic               res_strobe,
  input  result_t            res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  output int                 moves_pending,
  output int                 fail_count
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam logic [PADDR_W-1:0] ROWS_ADDR = PADDR_W'({REG_ROWS, 2'b00});
  localparam logic [PADDR_W-1:0] COLS_ADDR = PADDR_W'({REG_COLS, 2'b00});

  logic [CFG_W-1:0] rows_cfg;
  logic [CFG_W-1:0] cols_cfg;
  bit               seen [CELLS];
  int               trail_row [$];
  int               trail_col [$];
  int               here_row;
  int               here_col;
  bit               maze_over;
  result_t          moves_due [$];
  result_t          want;

  initial begin
    moves_pending = 0;
    fail_count = 0;
  end

  function automatic result_t next_move(input item_t w);
    int         nrows;
    int         ncols;
    int         nr;
    int         nc;
    int         srow;
    int         count;
    logic [1:0] opts [4];
    logic [1:0] dir;
    result_t    mv;
    nrows = (rows_cfg == 0) ? 1 : (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
    ncols = (cols_cfg == 0) ? 1 : (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
    mv = '0;
    if (w.cmd == CMD_START) begin
      srow = (int'(w.start_row) > nrows - 1) ? nrows - 1 : int'(w.start_row);
      foreach (seen[i]) seen[i] = 1'b0;
      here_row = srow;
      here_col = 0;
      seen[srow * MAX_COLS] = 1'b1;
      trail_row.delete();
      trail_col.delete();
      maze_over = 1'b0;
    end else if (maze_over) begin
      mv.done_res = 1'b1;
    end else begin
      count = 0;
      for (int d = 0; d < 4; d++) begin
        nr = here_row + ((d == DIR_UP) ? -1 : (d == DIR_DOWN) ? 1 : 0);
        nc = here_col + ((d == DIR_LEFT) ? -1 : (d == DIR_RIGHT) ? 1 : 0);
        if (nr >= 0 && nc >= 0 && nr < nrows && nc < ncols) begin
          if (!seen[nr * MAX_COLS + nc]) begin
            opts[count] = 2'(d);
            count++;
          end
        end
      end
      if (count > 0) begin
        dir = opts[int'(w.rand_value) % count];
        trail_row.push_back(here_row);
        trail_col.push_back(here_col);
        here_row += (dir == DIR_UP) ? -1 : (dir == DIR_DOWN) ? 1 : 0;
        here_col += (dir == DIR_LEFT) ? -1 : (dir == DIR_RIGHT) ? 1 : 0;
        seen[here_row * MAX_COLS + here_col] = 1'b1;
        mv.advanced = 1'b1;
        mv.direction = dir;
      end else if (trail_row.size() == 0) begin
        maze_over = 1'b1;
        mv.done_res = 1'b1;
      end else begin
        here_row = trail_row.pop_back();
        here_col = trail_col.pop_back();
      end
    end
    mv.cell_row = COORD_W'(here_row);
    mv.cell_col = COORD_W'(here_col);
    return mv;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_cfg = ROWS_RESET;
      cols_cfg = COLS_RESET;
      foreach (seen[i]) seen[i] = 1'b0;
      trail_row.delete();
      trail_col.delete();
      here_row = 0;
      here_col = 0;
      maze_over = 1'b1;
      moves_due.delete();
    end else begin
      if (res_strobe) begin
        if (moves_due.size() == 0) begin
          fail_count++;
          $display("%0t: result word with none due, got row %0d col %0d", $time,
                   res.cell_row, res.cell_col);
        end else begin
          want = moves_due.pop_front();
          check_field("cell_row", 32'(want.cell_row), 32'(res.cell_row));
          check_field("cell_col", 32'(want.cell_col), 32'(res.cell_col));
          check_field("advanced", 32'(want.advanced), 32'(res.advanced));
          check_field("direction", 32'(want.direction), 32'(res.direction));
          check_field("done_res", 32'(want.done_res), 32'(res.done_res));
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ROWS_ADDR) rows_cfg = pwdata[CFG_W-1:0];
          else if (paddr == COLS_ADDR) cols_cfg = pwdata[CFG_W-1:0];
        end else if (paddr == ROWS_ADDR) begin
          check_field("cell_rows read", PDATA_W'(rows_cfg), prdata);
        end else if (paddr == COLS_ADDR) begin
          check_field("cell_cols read", PDATA_W'(cols_cfg), prdata);
        end
      end
      if (start && !busy) moves_due.push_back(next_move(item));
    end
    moves_pending <= moves_due.size();
  end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the maze carving core. Drives a short directed
// run over the corner cases (step before any start, start row past the last
// row, out-of-range bounds, bounds changed in the middle of a maze, steps
// after completion), then random mazes of mostly small sizes walked to
// completion, restarted early or mixed with noise words, with random gaps
// on the item channel. The checker beside the core does all prediction.
// ----------------------------------------------------------------------------
module testbench;
  import mdfs_pkg::*;

  localparam int ITEMS = 1300;
  localparam int LIMIT = 400000;
  localparam logic [PADDR_W-1:0] ROWS_ADDR = PADDR_W'({REG_ROWS, 2'b00});
  localparam logic [PADDR_W-1:0] COLS_ADDR = PADDR_W'({REG_COLS, 2'b00});

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  item_t              item = '0;
  logic               res_strobe;
  result_t            res;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 moves_pending;
  int                 fail_count;
  int                 cycles = 0;
  int                 sent = 0;
  bit                 start_hi = 1'b0;
  logic [CFG_W-1:0]   rows_now = ROWS_RESET;
  logic [CFG_W-1:0]   cols_now = COLS_RESET;

  maze_dfs_carve_step_core dut (.*);

  maze_carve_checker carve_check (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic int fit(input logic [CFG_W-1:0] v, input int most);
    return (v == 0) ? 1 : (v > most) ? most : int'(v);
  endfunction

  function automatic int pick_dim(input int lo);
    int r;
    r = $urandom_range(99);
    if (r < 6) return 32;
    if (r < 12) return $urandom_range(0, 63);
    return $urandom_range(lo, 6);
  endfunction

  task automatic send_word(input logic op, input int row, input int rnd);
    item <= '{cmd: op, start_row: COORD_W'(row), rand_value: RAND_W'(rnd)};
    start <= 1'b1;
    start_hi = 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    if (!(sent >= 500 && sent < 760) && $urandom_range(99) < 18) begin
      start <= 1'b0;
      start_hi = 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (start_hi) begin
      start <= 1'b0;
      start_hi = 1'b0;
    end
    do @(posedge clk); while (moves_pending != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr, input int val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(input int nrows, input int ncols);
    drain();
    reg_access(1'b1, ROWS_ADDR, nrows);
    reg_access(1'b1, COLS_ADDR, ncols);
    reg_access(1'b0, ROWS_ADDR, 0);
    reg_access(1'b0, COLS_ADDR, 0);
    rows_now = CFG_W'(nrows);
    cols_now = CFG_W'(ncols);
  endtask

  task automatic run_maze();
    int nsteps;
    int cut;
    if ($urandom_range(99) < 35) set_size(pick_dim(2), pick_dim(1));
    nsteps = 2 * fit(rows_now, MAX_ROWS_DEF) * fit(cols_now, MAX_COLS_DEF) - 1
             + $urandom_range(0, 2);
    if ($urandom_range(99) < 12) nsteps = $urandom_range(0, nsteps);
    if (nsteps > 150) nsteps = $urandom_range(40, 150);
    cut = ($urandom_range(99) < 10) ? int'($urandom_range(0, nsteps)) : -1;
    send_word(CMD_START, $urandom_range(0, 31), $urandom_range(0, 65535));
    for (int k = 0; k < nsteps; k++) begin
      if (k == cut) set_size(pick_dim(2), pick_dim(1));
      send_word(CMD_STEP, $urandom_range(0, 31), $urandom_range(0, 65535));
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(3, 12))
      send_word(($urandom_range(99) < 25) ? CMD_START : CMD_STEP,
                $urandom_range(0, 31), $urandom_range(0, 65535));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_access(1'b0, ROWS_ADDR, 0);
    reg_access(1'b0, COLS_ADDR, 0);

    send_word(CMD_STEP, 0, 16'hFFFF);
    set_size(2, 1);
    send_word(CMD_START, 31, 0);
    repeat (3) send_word(CMD_STEP, 0, 0);
    send_word(CMD_STEP, 31, 16'hFFFF);
    set_size(2, 2);
    send_word(CMD_START, 0, 16'hFFFF);
    repeat (7) send_word(CMD_STEP, 0, 0);
    set_size(0, 63);
    send_word(CMD_START, 31, 0);
    send_word(CMD_STEP, 0, 16'hFFFF);
    set_size(63, 0);
    repeat (3) send_word(CMD_STEP, 0, 16'h5555);
    set_size(32, 32);
    send_word(CMD_START, 31, 16'hFFFF);
    send_word(CMD_STEP, 0, 16'h8000);
    send_word(CMD_STEP, 0, 0);

    while (sent < ITEMS) begin
      if ($urandom_range(99) < 8) noise_burst();
      else run_maze();
    end

    drain();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

### sim.f
hdl/mdfs_pkg.sv
hdl/mdfs_ram.sv
hdl/mdfs_ctrl.sv
hdl/mdfs_dpath.sv
hdl/maze_dfs_carve_step_core.sv
verif/maze_carve_checker.sv
verif/testbench.sv
